// File: design/complex_to_polar_selector_top_defines.svh
// Assertion macros used by the complex-to-polar selector checker.
`ifndef COMPLEX_TO_POLAR_SELECTOR_TOP_DEFINES_SVH
`define COMPLEX_TO_POLAR_SELECTOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define C2P_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define C2P_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/c2p_pkg.sv
// Package: types, constants and helpers of the complex-to-polar selector.
`timescale 1ns / 1ps
`default_nettype none
package c2p_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD_BITS    = 8;

  // CORDIC datapath widths
  localparam int XW = SAMPLE_BITS + GUARD_BITS + 3;  // x/y with gain headroom
  localparam int ZW = 34;                            // angle accumulator, pi = 2^31
  localparam int PW = XW - 1 + 20;                   // magnitude product
  localparam int CW = XW + 1;                        // saturation input width

  localparam int VALUE_W   = 17;
  localparam int NUM_KINDS = 5;
  localparam int CFG_IDX_W = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [19:0] INV_GAIN_Q20 = 20'd636751;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef logic signed [VALUE_W-1:0] value_t;

  localparam value_t VALUE_MAX_V = 17'sd65535;
  localparam value_t VALUE_MIN_V = -17'sd65536;
  localparam logic signed [CW-1:0] SAT_HI = CW'(65535);
  localparam logic signed [CW-1:0] SAT_LO = CW'(-65536);

  typedef enum logic [2:0] {
    KIND_REAL  = 3'd0,
    KIND_IMAG  = 3'd1,
    KIND_MAG   = 3'd2,
    KIND_PHASE = 3'd3,
    KIND_ZERO  = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMIT_REAL  = 3'd0,
    CFG_EMIT_IMAG  = 3'd1,
    CFG_EMIT_MAG   = 3'd2,
    CFG_EMIT_PHASE = 3'd3,
    CFG_EMIT_ZERO  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] real_part;
    logic signed [SAMPLE_BITS-1:0] imag_part;
  } in_item_t;

  typedef struct packed {
    value_t value;
    kind_e  kind;
    logic   last_of_sample;
  } res_item_t;

  // One finished sample, every quantity already saturated
  typedef struct packed {
    value_t re;
    value_t im;
    value_t mag;
    value_t phase;
  } polar_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic value_t sat_value(input logic signed [CW-1:0] v);
    value_t r;
    if (v > SAT_HI) begin
      r = VALUE_MAX_V;
    end else if (v < SAT_LO) begin
      r = VALUE_MIN_V;
    end else begin
      r = v[VALUE_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/c2p_front.sv
// Front end: sample intake and pipelined CORDIC vectoring to magnitude and phase.
`timescale 1ns / 1ps
`default_nettype none
module c2p_front
  import c2p_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  in_item_t   sample_i,
  input  fifo_stat_t fifo_stat_i,
  output logic       rec_push_o,
  output polar_rec_t rec_o
);

  localparam int NS = CORDIC_STAGES;
  localparam logic signed [ZW-1:0] Z_PI   = $signed({{(ZW-32){1'b0}}, 32'h8000_0000});
  localparam logic signed [ZW-1:0] Z_RND  = $signed(ZW'(32'h0000_8000));
  localparam logic [PW-1:0]        M_RND  = PW'(32'h0800_0000);
  localparam logic signed [ZW-17:0] PH_HI = (ZW-16)'(32768);
  localparam logic signed [ZW-17:0] PH_LO = (ZW-16)'(-32768);

  logic adv;
  logic v_q [0:NS+1];

  logic signed [XW-1:0] x_q [0:NS];
  logic signed [XW-1:0] y_q [0:NS-1];
  logic signed [ZW-1:0] z_q [0:NS+1];
  logic                 zero_q [0:NS+1];
  value_t               re_q [0:NS+1];
  value_t               im_q [0:NS+1];
  logic [PW-1:0]        prod_q;

  // entry
  logic signed [XW-1:0] re_x, im_x;
  logic                 neg;

  assign adv    = !fifo_stat_i.full;
  assign full_o = fifo_stat_i.full;

  assign re_x = XW'(sample_i.real_part) <<< GUARD_BITS;
  assign im_x = XW'(sample_i.imag_part) <<< GUARD_BITS;
  assign neg  = sample_i.real_part[SAMPLE_BITS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS + 1; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= push_i;
      for (int k = 0; k <= NS; k++) begin
        v_q[k+1] <= v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0]    <= neg ? -re_x : re_x;
      y_q[0]    <= neg ? -im_x : im_x;
      z_q[0]    <= !neg ? '0 : (sample_i.imag_part[SAMPLE_BITS-1] ? -Z_PI : Z_PI);
      zero_q[0] <= (sample_i.real_part == '0) && (sample_i.imag_part == '0);
      re_q[0]   <= sat_value(CW'(sample_i.real_part));
      im_q[0]   <= sat_value(CW'(sample_i.imag_part));
    end
  end

  // one micro-rotation per stage
  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    logic                 yneg;

    assign xs   = x_q[k] >>> k;
    assign ys   = y_q[k] >>> k;
    assign at   = $signed(ZW'(ATAN_TAB[k]));
    assign yneg = y_q[k][XW-1];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        x_q[k+1]    <= yneg ? x_q[k] - ys : x_q[k] + ys;
        z_q[k+1]    <= yneg ? z_q[k] - at : z_q[k] + at;
        zero_q[k+1] <= zero_q[k];
        re_q[k+1]   <= re_q[k];
        im_q[k+1]   <= im_q[k];
      end
    end

    if (k < NS - 1) begin : g_y
      always_ff @(posedge clk_i) begin
        if (adv) begin
          y_q[k+1] <= yneg ? y_q[k] + xs : y_q[k] - xs;
        end
      end
    end
  end

  // gain correction multiply (x is non-negative after the pre-rotation)
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q       <= PW'(x_q[NS][XW-2:0]) * PW'(INV_GAIN_Q20);
      z_q[NS+1]    <= z_q[NS];
      zero_q[NS+1] <= zero_q[NS];
      re_q[NS+1]   <= re_q[NS];
      im_q[NS+1]   <= im_q[NS];
    end
  end

  // rounding and saturation of the final stage
  logic [PW-1:0]          mag_rnd;
  logic signed [CW-1:0]   mag_ext;
  logic signed [ZW-1:0]   z_rnd;
  logic signed [ZW-17:0]  ph;
  value_t                 ph_sat;

  always_comb begin
    mag_rnd = prod_q + M_RND;
    mag_ext = $signed({{(CW-(PW-28)){1'b0}}, mag_rnd[PW-1:28]});
    z_rnd   = z_q[NS+1] + Z_RND;
    ph      = $signed(z_rnd[ZW-1:16]);
    if (ph > PH_HI) begin
      ph_sat = VALUE_W'(PH_HI);
    end else if (ph < PH_LO) begin
      ph_sat = VALUE_W'(PH_LO);
    end else begin
      ph_sat = ph[VALUE_W-1:0];
    end
  end

  assign rec_push_o = v_q[NS+1] && adv;
  assign rec_o.re    = re_q[NS+1];
  assign rec_o.im    = im_q[NS+1];
  assign rec_o.mag   = zero_q[NS+1] ? '0 : sat_value(mag_ext);
  assign rec_o.phase = zero_q[NS+1] ? '0 : ph_sat;

endmodule
`default_nettype wire

// File: design/c2p_fifo.sv
// Short queue of finished samples between the CORDIC front and the result serializer.
`timescale 1ns / 1ps
`default_nettype none
module c2p_fifo
  import c2p_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  polar_rec_t rec_i,
  input  logic       pop_i,
  output polar_rec_t rec_o,
  output fifo_stat_t stat_o
);

  polar_rec_t           mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, rd_q;
  logic [FIFO_CW-1:0]   cnt_q;
  logic                 do_push, do_pop;

  assign stat_o.full  = cnt_q == FIFO_CW'(FIFO_DEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rec_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/c2p_back.sv
// Back end: walks the enabled kinds of each sample and drives the result register.
`timescale 1ns / 1ps
`default_nettype none
module c2p_back
  import c2p_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [NUM_KINDS-1:0] emit_mask_i,
  input  polar_rec_t           rec_i,
  input  fifo_stat_t           fifo_stat_i,
  output logic                 rec_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output res_item_t            result_o
);

  logic [NUM_KINDS-1:0] mask_q, mask_d, rem, first;
  polar_rec_t           wk_q, wk_d;
  logic                 out_v_q, out_v_d;
  res_item_t            res_q, res_d;
  kind_e                sel;
  logic                 emit_go, load;
  value_t               sel_val;

  always_comb begin
    rem   = mask_q & (mask_q - NUM_KINDS'(1));
    first = mask_q & ~rem;
    sel   = KIND_REAL;
    for (int k = 0; k < NUM_KINDS; k++) begin
      if (first[k]) begin
        sel = kind_e'(3'(k));
      end
    end

    unique case (sel)
      KIND_REAL:  sel_val = wk_q.re;
      KIND_IMAG:  sel_val = wk_q.im;
      KIND_MAG:   sel_val = wk_q.mag;
      KIND_PHASE: sel_val = wk_q.phase;
      KIND_ZERO:  sel_val = '0;
      default:    sel_val = '0;
    endcase

    emit_go = (|mask_q) && (!out_v_q || pop_i);
    // next sample may enter as the current one hands off its last result
    load    = (!(|mask_q) || (emit_go && !(|rem))) && !fifo_stat_i.empty;

    mask_d  = mask_q;
    wk_d    = wk_q;
    res_d   = res_q;
    out_v_d = out_v_q && !pop_i;

    if (emit_go) begin
      out_v_d              = 1'b1;
      res_d.value          = sel_val;
      res_d.kind           = sel;
      res_d.last_of_sample = !(|rem);
      mask_d               = rem;
    end
    if (load) begin
      wk_d   = rec_i;
      mask_d = emit_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      mask_q  <= mask_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wk_q  <= wk_d;
    res_q <= res_d;
  end

  assign rec_pop_o = load;
  assign empty_o   = !out_v_q;
  assign result_o  = res_q;

endmodule
`default_nettype wire

// File: design/complex_to_polar_selector_top.sv
// Top level of the complex-to-polar selector: config registers and the three parts.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  sample   | push / full               | sample_i  (real_part, imag_part)
//  result   | pop / empty               | result_o  (value, kind, last_of_sample)
//  config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i (bit 0)
//
// A sample runs through 1 entry stage, CORDIC_STAGES rotation stages and one
// gain-multiply stage, then a 4-item queue. The result register emits one item
// per cycle while it is empty or being popped, one per enabled kind of the
// sample; a sample with no enabled kind emits no item. A pushed sample passes
// the pipeline, the queue and the back end's working register before its first
// result reaches the result register. full follows the queue: a stalled result
// side fills it, then the pipeline holds. Reset clears the enables, the pipeline
// valids, the queue and the result valid flag; the config port is always ready.
`timescale 1ns / 1ps
`default_nettype none
module complex_to_polar_selector_top
  import c2p_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             sample_i,
  output logic                 empty,
  input  logic                 pop,
  output res_item_t            result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i
);

  // enable bit per kind, indexed by kind code
  logic [NUM_KINDS-1:0] emit_q, emit_d;

  always_comb begin
    emit_d = emit_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_EMIT_REAL:  emit_d[KIND_REAL]  = cfg_data_i;
        CFG_EMIT_IMAG:  emit_d[KIND_IMAG]  = cfg_data_i;
        CFG_EMIT_MAG:   emit_d[KIND_MAG]   = cfg_data_i;
        CFG_EMIT_PHASE: emit_d[KIND_PHASE] = cfg_data_i;
        CFG_EMIT_ZERO:  emit_d[KIND_ZERO]  = cfg_data_i;
        default:        emit_d = emit_q;   // writes past the list are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= '0;
    end else begin
      emit_q <= emit_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  fifo_stat_t fifo_stat;
  polar_rec_t front_rec, head_rec;
  logic       rec_push, rec_pop;

  c2p_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .sample_i    (sample_i),
    .fifo_stat_i (fifo_stat),
    .rec_push_o  (rec_push),
    .rec_o       (front_rec)
  );

  c2p_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rec_push),
    .rec_i  (front_rec),
    .pop_i  (rec_pop),
    .rec_o  (head_rec),
    .stat_o (fifo_stat)
  );

  c2p_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_mask_i (emit_q),
    .rec_i       (head_rec),
    .fifo_stat_i (fifo_stat),
    .rec_pop_o   (rec_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule
`default_nettype wire

// File: design/c2p_checker.sv
// Port-level checks of the complex-to-polar selector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_to_polar_selector_top_defines.svh"
module c2p_checker
  import c2p_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input res_item_t result_o
);

  `C2P_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result_o), "result changed while stalled")
  `C2P_ASSERT_SAME(a_zero, !empty && result_o.kind == KIND_ZERO, result_o.value == '0, "zero kind nonzero")
  `C2P_ASSERT_SAME(a_mag, !empty && result_o.kind == KIND_MAG, !result_o.value[VALUE_W-1], "negative magnitude")
  `C2P_ASSERT_SAME(a_phase, !empty && result_o.kind == KIND_PHASE, (result_o.value >= -17'sd32768) && (result_o.value <= 17'sd32768), "phase beyond pi")

endmodule

bind complex_to_polar_selector_top c2p_checker u_c2p_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
`default_nettype wire
